// ----- src/srgb_pc_pkg.sv -----
`default_nettype none

package srgb_pc_pkg;

    localparam int PIX_W      = 32;
    localparam int COV_W      = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam int ROOT_W     = 50;
    localparam int ROOT_STEPS = 25;

    localparam logic [CFG_IDX_W-1:0] REG_OVER_ENABLE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COVERAGE_MODE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COVERAGE_FIRST = 8'd2;

    localparam logic [1:0] COV_IGNORE = 2'd0;
    localparam logic [1:0] COV_SCALE  = 2'd1;
    localparam logic [1:0] COV_LERP   = 2'd2;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_SCALE,
        OP_LERP,
        OP_OVER
    } t_op;

    typedef logic [24:0] t_lut [256];

    function automatic longint unsigned fifth_q30(input longint unsigned y);
        longint unsigned y2;
        longint unsigned y4;
        y2 = (y * y) >> 30;
        y4 = (y2 * y2) >> 30;
        return (y4 * y) >> 30;
    endfunction

    function automatic t_lut build_decode_lut(input int lb);
        t_lut            lut;
        longint unsigned t;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned t2;
        longint unsigned r2;
        longint unsigned l30;
        for (int i = 0; i < 256; i++) begin
            if (i <= 10) begin
                lut[i] = 25'(((longint'(i) * 100 << lb) + 164730) / 329460);
            end else begin
                t  = ((longint'(i) * 1000 + 14025) << 30) / 269025;
                lo = 0;
                hi = longint'(1) << 30;
                while (lo < hi) begin
                    mid = (lo + hi + 1) >> 1;
                    if (fifth_q30(mid) <= t) begin
                        lo = mid;
                    end else begin
                        hi = mid - 1;
                    end
                end
                t2     = (t * t) >> 30;
                r2     = (lo * lo) >> 30;
                l30    = (t2 * r2) >> 30;
                lut[i] = 25'((l30 + (longint'(1) << (29 - lb))) >> (30 - lb));
            end
        end
        return lut;
    endfunction

    function automatic t_lut build_unit_lut(input int lb);
        t_lut lut;
        for (int i = 0; i < 256; i++) begin
            lut[i] = 25'(((longint'(i) << lb) + 127) / 255);
        end
        return lut;
    endfunction

    function automatic logic [7:0] round_byte(input logic [31:0] v);
        logic [32:0] b;
        b = ({1'b0, v} + 33'd32768) >> 16;
        return (b > 33'd255) ? 8'hFF : b[7:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/srgb_pc_if.sv -----
`default_nettype none

interface srgb_pc_pix_if import srgb_pc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] src_pixel;
    logic [PIX_W-1:0] dst_pixel;
    logic [COV_W-1:0] coverage;

    modport source (output valid, output src_pixel, output dst_pixel, output coverage,
                    input ready);
    modport sink   (input valid, input src_pixel, input dst_pixel, input coverage,
                    output ready);
endinterface

interface srgb_pc_out_if import srgb_pc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_pixel;

    modport source (output valid, output out_pixel, input ready);
    modport sink   (input valid, input out_pixel, output ready);
endinterface

interface srgb_pc_cfg_if import srgb_pc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/srgb_pixel_compositor_core.sv -----
`default_nettype none

// Linear-light sRGB compositor pipeline: decode, three mixing steps for the coverage
// and source-over passes, two chains of 25 square-root cells per colour channel,
// then an output multiply register and an output byte register. One pixel per clock
// in and out while the output is not stalled. The square-root cell chains make up
// most of the pipeline. Idle stages collapse, so a stalled output still lets new
// transactions in until the pipeline is full. Configuration is taken at any time
// but is meant to change only when empty. There is no clearing pass after reset.

module srgb_pixel_compositor_core import srgb_pc_pkg::*; #(
    parameter int LINEAR_BITS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    srgb_pc_pix_if.sink   i_pix,
    srgb_pc_cfg_if.sink   i_cfg,
    srgb_pc_out_if.source o_res
);

    localparam int LB  = LINEAR_BITS;
    localparam int LW  = LB + 2;
    localparam int NR  = ROOT_STEPS;
    localparam int C0  = 7;
    localparam int NS  = C0 + 2 * NR + 2;
    localparam int AP  = 2 * NR + 1;
    localparam t_lut DEC_LUT  = build_decode_lut(LB);
    localparam t_lut UNIT_LUT = build_unit_lut(LB);

    logic          r_over_en;
    logic [1:0]    r_cov_mode;
    logic          r_cov_first;
    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;
    logic [NS-1:0] n_vin;

    logic [LW-1:0] r_s0 [4];
    logic [LW-1:0] r_d0 [4];
    logic [LB:0]   r_c0;
    logic [LW-1:0] w_s1 [4];
    logic [LW-1:0] w_d1 [4];
    logic [LB:0]   w_c1;
    logic [LW-1:0] w_s2 [4];
    logic [LW-1:0] w_d2 [4];
    logic [LB:0]   w_c2;
    logic [LW-1:0] w_s3 [4];
    logic [LW-1:0] w_d3 [4];
    logic [LB:0]   w_c3;
    t_op           w_op0;
    t_op           w_op1;
    t_op           w_op2;
    t_op           w_cov_op;

    logic [LW+8:0] n_am;
    logic [7:0]    n_ab;
    logic [7:0]    r_apipe [AP];
    logic [7:0]    r_abyte;
    logic [7:0]    w_byte [3];

    always_comb begin
        case (r_cov_mode)
            COV_SCALE: w_cov_op = OP_SCALE;
            COV_LERP:  w_cov_op = OP_LERP;
            default:   w_cov_op = OP_PASS;
        endcase
        w_op0 = r_cov_first ? w_cov_op : OP_PASS;
        w_op1 = r_over_en ? OP_OVER : OP_PASS;
        w_op2 = r_cov_first ? OP_PASS : w_cov_op;
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_over_en   <= 1'b1;
            r_cov_mode  <= COV_IGNORE;
            r_cov_first <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_OVER_ENABLE:    r_over_en   <= i_cfg.data[0];
                REG_COVERAGE_MODE:  r_cov_mode  <= i_cfg.data[1:0];
                REG_COVERAGE_FIRST: r_cov_first <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_en
        assign w_en[k] = ~(&r_v[NS-1:k]) | o_res.ready;
    end

    assign n_vin       = {r_v[NS-2:0], i_pix.valid};
    assign i_pix.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= n_vin[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int k = 0; k < 3; k++) begin
                r_s0[k] <= LW'(DEC_LUT[i_pix.src_pixel[8*k +: 8]]);
                r_d0[k] <= LW'(DEC_LUT[i_pix.dst_pixel[8*k +: 8]]);
            end
            r_s0[3] <= LW'(UNIT_LUT[i_pix.src_pixel[31:24]]);
            r_d0[3] <= LW'(UNIT_LUT[i_pix.dst_pixel[31:24]]);
            r_c0    <= (LB+1)'(UNIT_LUT[i_pix.coverage]);
        end
    end

    srgb_pc_mix #(.LB(LB)) u_mix0 (
        .i_clk (i_clk), .i_en (w_en[2:1]), .i_op (w_op0),
        .i_s (r_s0), .i_d (r_d0), .i_c (r_c0),
        .o_s (w_s1), .o_d (w_d1), .o_c (w_c1)
    );

    srgb_pc_mix #(.LB(LB)) u_mix1 (
        .i_clk (i_clk), .i_en (w_en[4:3]), .i_op (w_op1),
        .i_s (w_s1), .i_d (w_d1), .i_c (w_c1),
        .o_s (w_s2), .o_d (w_d2), .o_c (w_c2)
    );

    srgb_pc_mix #(.LB(LB)) u_mix2 (
        .i_clk (i_clk), .i_en (w_en[6:5]), .i_op (w_op2),
        .i_s (w_s2), .i_d (w_d2), .i_c (w_c2),
        .o_s (w_s3), .o_d (w_d3), .o_c (w_c3)
    );

    // alpha travels alongside the root chains
    always_comb begin
        n_am = (LW+9)'(w_s3[3]) * (LW+9)'(255) + ((LW+9)'(1) << (LB - 1));
        n_ab = ((n_am >> LB) > (LW+9)'(255)) ? 8'hFF : 8'(n_am >> LB);
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < AP; j++) begin
            if (w_en[C0+j]) begin
                r_apipe[j] <= (j == 0) ? n_ab : r_apipe[(j == 0) ? 0 : j - 1];
            end
        end
        if (w_en[NS-1]) begin
            r_abyte <= r_apipe[AP-1];
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        logic [ROOT_W-1:0] n_arg1;
        logic              n_low;
        logic [23:0]       n_y;
        logic [NR-1:0]     w_q;
        logic [24:0]       w_tag1;
        logic [23:0]       n_z;
        logic [ROOT_W-1:0] n_arg2;
        logic [NR-1:0]     w_f;
        logic [NR+24:0]    w_tag2;
        logic [49:0]       r_m1;
        logic [49:0]       r_m2;
        logic              r_low;
        logic [23:0]       r_z;
        logic [25:0]       n_h;
        logic [25:0]       n_hv;
        logic [7:0]        r_byte;

        always_comb begin
            n_arg1 = ROOT_W'(w_s3[g]) << (48 - LB);
            n_low  = (64'(w_s3[g]) * 64'd100000) < (64'd349 << LB);
            n_y    = 24'(((64'(w_s3[g]) * 64'd32946) << 16) >> LB);
        end

        srgb_pc_root #(.TW(25)) u_root_q (
            .i_clk  (i_clk),
            .i_en   (w_en[C0 +: NR]),
            .i_arg  (n_arg1),
            .i_tag  ({n_low, n_y}),
            .o_root (w_q),
            .o_tag  (w_tag1)
        );

        // divide by ten via reciprocal, exact over the low-branch range
        always_comb begin
            n_z    = 24'((48'(w_tag1[23:0]) * 48'd13421773) >> 27);
            n_arg2 = ROOT_W'(w_q) << 24;
        end

        srgb_pc_root #(.TW(NR + 25)) u_root_f (
            .i_clk  (i_clk),
            .i_en   (w_en[C0+NR +: NR]),
            .i_arg  (n_arg2),
            .i_tag  ({w_q, w_tag1[24], n_z}),
            .o_root (w_f),
            .o_tag  (w_tag2)
        );

        always_ff @(posedge i_clk) begin
            if (w_en[C0+2*NR]) begin
                r_m1  <= 50'(w_f) * 50'd7062390;
                r_m2  <= 50'(w_tag2[NR+24:25]) * 50'd11339093;
                r_low <= w_tag2[24];
                r_z   <= w_tag2[23:0];
            end
        end

        always_comb begin
            n_h  = 26'((51'(r_m1) + 51'(r_m2) + (51'(1) << 23)) >> 24);
            n_hv = (n_h < 26'd1689803) ? '0 : n_h - 26'd1689803;
        end

        always_ff @(posedge i_clk) begin
            if (w_en[NS-1]) begin
                r_byte <= r_low ? round_byte(32'(r_z)) : round_byte(32'(n_hv));
            end
        end

        assign w_byte[g] = r_byte;
    end

    assign o_res.valid     = r_v[NS-1];
    assign o_res.out_pixel = {r_abyte, w_byte[2], w_byte[1], w_byte[0]};

endmodule

`default_nettype wire

// ----- src/srgb_pc_mix.sv -----
`default_nettype none

module srgb_pc_mix import srgb_pc_pkg::*; #(
    parameter int LB = 16
) (
    input  wire logic          i_clk,
    input  wire logic [1:0]    i_en,
    input  wire t_op           i_op,
    input  wire logic [LB+1:0] i_s [4],
    input  wire logic [LB+1:0] i_d [4],
    input  wire logic [LB:0]   i_c,
    output logic      [LB+1:0] o_s [4],
    output logic      [LB+1:0] o_d [4],
    output logic      [LB:0]   o_c
);

    localparam int LW = LB + 2;
    localparam int PW = 2 * LW;
    localparam logic [LB:0] ONE  = (LB+1)'(1) << LB;
    localparam logic [PW:0] HALF = (PW+1)'(1) << (LB - 1);

    logic [PW-1:0] n_p0 [4];
    logic [PW-1:0] n_p1 [4];
    logic [PW-1:0] r_p0 [4];
    logic [PW-1:0] r_p1 [4];
    logic [LW-1:0] r_d1 [4];
    logic [LB:0]   r_c1;
    logic [LB:0]   n_inv_c;
    logic [LB:0]   n_f;
    logic [LW-1:0] r_s2 [4];
    logic [LW-1:0] r_d2 [4];
    logic [LB:0]   r_c2;

    // alpha never exceeds one, so the source-over factor fits
    always_comb begin
        n_inv_c = ONE - i_c;
        n_f     = ONE - i_s[3][LB:0];
        for (int k = 0; k < 4; k++) begin
            case (i_op)
                OP_SCALE: begin
                    n_p0[k] = PW'(i_s[k]) * PW'(i_c);
                    n_p1[k] = '0;
                end
                OP_LERP: begin
                    n_p0[k] = PW'(i_s[k]) * PW'(i_c);
                    n_p1[k] = PW'(i_d[k]) * PW'(n_inv_c);
                end
                OP_OVER: begin
                    n_p0[k] = PW'(i_s[k]) << LB;
                    n_p1[k] = PW'(i_d[k]) * PW'(n_f);
                end
                default: begin
                    n_p0[k] = PW'(i_s[k]) << LB;
                    n_p1[k] = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p0 <= n_p0;
            r_p1 <= n_p1;
            r_d1 <= i_d;
            r_c1 <= i_c;
        end
        if (i_en[1]) begin
            for (int k = 0; k < 4; k++) begin
                r_s2[k] <= LW'(({1'b0, r_p0[k]} + {1'b0, r_p1[k]} + HALF) >> LB);
            end
            r_d2 <= r_d1;
            r_c2 <= r_c1;
        end
    end

    assign o_s = r_s2;
    assign o_d = r_d2;
    assign o_c = r_c2;

endmodule

`default_nettype wire

// ----- src/srgb_pc_sqrt_cell.sv -----
`default_nettype none

module srgb_pc_sqrt_cell import srgb_pc_pkg::*; #(
    parameter int STEP = 0,
    parameter int TW   = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [ROOT_W-1:0] i_v,
    input  wire logic [ROOT_W-1:0] i_res,
    input  wire logic [TW-1:0]     i_tag,
    output logic      [ROOT_W-1:0] o_v,
    output logic      [ROOT_W-1:0] o_res,
    output logic      [TW-1:0]     o_tag
);

    localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * STEP);

    logic [ROOT_W-1:0] n_try;
    logic [ROOT_W-1:0] n_v;
    logic [ROOT_W-1:0] n_res;
    logic [ROOT_W-1:0] r_v;
    logic [ROOT_W-1:0] r_res;
    logic [TW-1:0]     r_tag;

    always_comb begin
        n_try = i_res + BIT;
        if (i_v >= n_try) begin
            n_v   = i_v - n_try;
            n_res = (i_res >> 1) + BIT;
        end else begin
            n_v   = i_v;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v   <= n_v;
            r_res <= n_res;
            r_tag <= i_tag;
        end
    end

    assign o_v   = r_v;
    assign o_res = r_res;
    assign o_tag = r_tag;

endmodule

`default_nettype wire

// ----- src/srgb_pc_root.sv -----
`default_nettype none

module srgb_pc_root import srgb_pc_pkg::*; #(
    parameter int TW = 1
) (
    input  wire logic                  i_clk,
    input  wire logic [ROOT_STEPS-1:0] i_en,
    input  wire logic [ROOT_W-1:0]     i_arg,
    input  wire logic [TW-1:0]         i_tag,
    output logic      [ROOT_STEPS-1:0] o_root,
    output logic      [TW-1:0]         o_tag
);

    logic [ROOT_W-1:0] w_v   [ROOT_STEPS+1];
    logic [ROOT_W-1:0] w_res [ROOT_STEPS+1];
    logic [TW-1:0]     w_tag [ROOT_STEPS+1];

    assign w_v[0]   = i_arg;
    assign w_res[0] = '0;
    assign w_tag[0] = i_tag;

    for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_cell
        srgb_pc_sqrt_cell #(
            .STEP (ROOT_STEPS - 1 - g),
            .TW   (TW)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en[g]),
            .i_v   (w_v[g]),
            .i_res (w_res[g]),
            .i_tag (w_tag[g]),
            .o_v   (w_v[g+1]),
            .o_res (w_res[g+1]),
            .o_tag (w_tag[g+1])
        );
    end

    assign o_root = w_res[ROOT_STEPS][ROOT_STEPS-1:0];
    assign o_tag  = w_tag[ROOT_STEPS];

endmodule

`default_nettype wire
